// ----- hw/rtl/sha256_pkg.sv -----
package sha256_pkg;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// one full block handed from the packer to the compressor
	typedef struct packed {
		logic [511:0] words;  // word 0 in the top bits
		logic         first;  // first block of a message: start from H_INIT
		logic         final_blk;  // emit digest after this block
	} sha_blk_t;

	localparam int QDEPTH = 2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- hw/rtl/sha_front.sv -----
module sha_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  has_byte,
	input  logic                  last,
	output logic                  blk_valid,
	input  logic                  blk_ready,
	output sha256_pkg::sha_blk_t  blk
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		PAD_NONE  = 3'b001,
		PAD_FINAL = 3'b010,  // final block pending or being queued
		PAD_LEN   = 3'b100   // block holding the length still to build
	} pad_st_t;

	logic [31:0]  blk_w_q [16];
	logic [63:0]  bit_count_q;
	logic         first_q;
	pad_st_t      pad_q;
	logic         pend_q;    // full block waiting to be handed over
	logic         pend_final_q;
	logic [5:0]   pos;
	logic [511:0] packed_w;

	assign pos = bit_count_q[8:3];
	assign in_ready = !pend_q && pad_q == PAD_NONE;

	always_comb begin
		for (int i = 0; i < 16; i++) packed_w[511 - 32*i -: 32] = blk_w_q[i];
	end

	assign blk_valid = pend_q;
	assign blk.words = packed_w;
	assign blk.first = first_q;
	assign blk.final_blk = pend_final_q;

	// gather bytes, build padding blocks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) blk_w_q[i] <= '0;
			bit_count_q <= '0;
			first_q <= 1'b1;
			pad_q <= PAD_NONE;
			pend_q <= 1'b0;
			pend_final_q <= 1'b0;
		end else begin
			logic [31:0] w [16];
			logic [63:0] cnt;
			logic [5:0]  p;
			w = blk_w_q;
			cnt = bit_count_q;
			p = pos;
			if (pend_q && blk_ready) begin
				first_q <= pend_final_q;
				if (pad_q == PAD_LEN) begin
					// length goes in a fresh zero block
					for (int i = 0; i < 16; i++) w[i] = '0;
					// data filled the previous block: the one bit opens this one
					if (pos == 6'd0) w[0] = 32'h8000_0000;
					w[14] = bit_count_q[63:32];
					w[15] = bit_count_q[31:0];
					pend_final_q <= 1'b1;
					pad_q <= PAD_FINAL;
				end else begin
					pend_q <= 1'b0;
					if (pad_q == PAD_FINAL) begin
						pad_q <= PAD_NONE;
						bit_count_q <= '0;
					end
				end
			end else if (in_valid && in_ready) begin
				if (has_byte) begin
					if (p[1:0] == 2'd0) w[p[5:2]] = '0;
					w[p[5:2]][{~p[1:0], 3'b000} +: 8] = data_byte;
					cnt = bit_count_q + 64'd8;
				end
				bit_count_q <= cnt;
				if (last && has_byte && pos == 6'd63) begin
					// full block now, one bit and length in the next
					pend_q <= 1'b1;
					pend_final_q <= 1'b0;
					pad_q <= PAD_LEN;
				end else if (last) begin
					p = cnt[8:3];
					if (p[1:0] == 2'd0) w[p[5:2]] = '0;
					w[p[5:2]][{~p[1:0], 3'b000} +: 8] = 8'h80;
					for (int i = 0; i < 16; i++)
						if (4'(i) > p[5:2]) w[i] = '0;
					pend_q <= 1'b1;
					if (p >= 6'd56) begin
						pend_final_q <= 1'b0;
						pad_q <= PAD_LEN;
					end else begin
						w[14] = cnt[63:32];
						w[15] = cnt[31:0];
						pend_final_q <= 1'b1;
						pad_q <= PAD_FINAL;
					end
				end else if (has_byte && pos == 6'd63) begin
					pend_q <= 1'b1;
					pend_final_q <= 1'b0;
				end
			end
			blk_w_q <= w;
		end
	end
endmodule

// ----- hw/rtl/sha_queue.sv -----
module sha_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  sha256_pkg::sha_blk_t  wr_blk,
	output logic                  rd_valid,
	input  logic                  rd_ready,
	output sha256_pkg::sha_blk_t  rd_blk
);
	import sha256_pkg::*;

	sha_blk_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = cnt_q != 2'(QDEPTH);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_blk = mem_q[rp_q];

	// write at tail, drop at head
	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end
endmodule

// ----- hw/rtl/sha_core.sv -----
module sha_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  blk_valid,
	output logic                  blk_ready,
	input  sha256_pkg::sha_blk_t  blk,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           digest_word,
	output logic [2:0]            word_index,
	output logic                  last_word
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} st_t;

	st_t         st_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  idx_q;
	logic [31:0] wt, w15, w2, s0, s1, t1, t2, a, e;

	assign blk_ready = st_q == ST_IDLE;
	assign out_valid = st_q == ST_OUT;
	assign digest_word = h_q[idx_q];
	assign word_index = idx_q;
	assign last_word = idx_q == 3'd7;

	// schedule word and round function
	always_comb begin
		w15 = w_q[1];
		w2 = w_q[14];
		s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
		s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
		wt = w_q[0];
		a = v_q[0];
		e = v_q[4];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[rnd_q] + wt;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= '0;
				h_q[i] <= H_INIT[i];
			end
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (blk_valid) begin
						for (int i = 0; i < 16; i++) w_q[i] <= blk.words[511 - 32*i -: 32];
						for (int i = 0; i < 8; i++) begin
							v_q[i] <= blk.first ? H_INIT[i] : h_q[i];
							if (blk.first) h_q[i] <= H_INIT[i];
						end
						fin_q <= blk.final_blk;
						rnd_q <= '0;
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// one round a cycle; schedule slides as a 16-word window
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
					w_q[15] <= w_q[0] + s0 + w_q[9] + s1;
					v_q[0] <= t1 + t2;
					v_q[1] <= v_q[0];
					v_q[2] <= v_q[1];
					v_q[3] <= v_q[2];
					v_q[4] <= v_q[3] + t1;
					v_q[5] <= v_q[4];
					v_q[6] <= v_q[5];
					v_q[7] <= v_q[6];
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						h_q[0] <= h_q[0] + t1 + t2;
						h_q[4] <= h_q[4] + v_q[3] + t1;
						for (int i = 1; i < 8; i++)
							if (i != 4) h_q[i] <= h_q[i] + v_q[i - 1];
						idx_q <= '0;
						st_q <= fin_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/sha256_message_digest.sv -----
// SHA-256 digest of a byte stream.
// Input channel s_axis: one beat per byte (tdata = data_byte), tuser[0] =
// has_byte (0 lets an empty closing beat end the message), tlast ends the
// message. Output channel m_axis: eight beats per message, most significant
// digest word first; tuser holds the word index, tlast the eighth word.
// Bytes are taken one a cycle while a block fills; every 64 bytes a block is
// queued and compressed by a single round unit, so the round loop sets the
// sustained rate near one byte per cycle. The packer holds off for one cycle
// as each finished block moves to the queue, longer while no slot is free,
// and from a last beat until its final padded block is queued.
// A last beat adds one or two padded blocks; the digest follows once the final
// block's rounds are done, and one word moves per beat.
// A stalled receiver holds the current word; the compressor waits and the
// queue fills behind it before input is held off.
// Reset restores the initial hash values, clears the length and the queue.
module sha256_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);
	import sha256_pkg::*;

	sha_blk_t f_blk, c_blk;
	logic f_valid, f_ready, c_valid, c_ready;

	sha_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.data_byte(s_axis_tdata), .has_byte(s_axis_tuser), .last(s_axis_tlast),
		.blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
	);

	sha_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_blk(f_blk),
		.rd_valid(c_valid), .rd_ready(c_ready), .rd_blk(c_blk)
	);

	sha_core u_core (
		.clk, .arst_n,
		.blk_valid(c_valid), .blk_ready(c_ready), .blk(c_blk),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.digest_word(m_axis_tdata), .word_index(m_axis_tuser),
		.last_word(m_axis_tlast)
	);
endmodule
